// ----- rtl/tun_pkg.sv -----
// shared types and pipeline constants for the triangle unit normal block
package tun_pkg;

    // register stages in the cross product and squaring sections
    localparam int CROSS_LAT  = 3;
    localparam int SQUARE_LAT = 3;

    // extra headroom bits on the search residual
    localparam int RES_GUARD  = 4;

    // pipeline control shared by every stage
    typedef struct packed {
        logic en;
    } t_stage_ctl;

endpackage

// ----- rtl/tun_cross.sv -----
// edge vectors and exact cross product, three register stages
module tun_cross #(
    parameter int CW  = 20,
    parameter int EW  = CW + 1,
    parameter int CPW = 2 * EW + 1
) (
    input  logic                  i_clk,
    input  tun_pkg::t_stage_ctl   i_ctl,
    input  logic [9*CW-1:0]       i_pts,
    output logic signed [CPW-1:0] o_c [3]
);

    logic signed [EW-1:0]    r_e1 [3];
    logic signed [EW-1:0]    r_e2 [3];
    logic signed [2*EW-1:0]  r_p  [3];
    logic signed [2*EW-1:0]  r_q  [3];
    logic signed [CPW-1:0]   r_c  [3];

    // edge vectors p2-p1 and p3-p1
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int a = 0; a < 3; a++) begin
                r_e1[a] <= EW'($signed(i_pts[CW*(3+a) +: CW]))
                         - EW'($signed(i_pts[CW*a +: CW]));
                r_e2[a] <= EW'($signed(i_pts[CW*(6+a) +: CW]))
                         - EW'($signed(i_pts[CW*a +: CW]));
            end
        end
    end

    // six partial products
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_p[0] <= r_e1[1] * r_e2[2];
            r_q[0] <= r_e1[2] * r_e2[1];
            r_p[1] <= r_e1[2] * r_e2[0];
            r_q[1] <= r_e1[0] * r_e2[2];
            r_p[2] <= r_e1[0] * r_e2[1];
            r_q[2] <= r_e1[1] * r_e2[0];
        end
    end

    // cross product components
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int a = 0; a < 3; a++) begin
                r_c[a] <= CPW'(r_p[a]) - CPW'(r_q[a]);
            end
        end
    end

    assign o_c = r_c;

endmodule

// ----- rtl/tun_square.sv -----
// squared components, squared length and search seed, three register stages
module tun_square #(
    parameter int CPW = 43,
    parameter int CM  = CPW - 1,
    parameter int SQW = 2 * CM,
    parameter int SW  = SQW + 2,
    parameter int NW  = 16,
    parameter int RW  = SW + 2 * NW + tun_pkg::RES_GUARD
) (
    input  logic                  i_clk,
    input  tun_pkg::t_stage_ctl   i_ctl,
    input  logic signed [CPW-1:0] i_c [3],
    output logic signed [RW-1:0]  o_r [3],
    output logic signed [RW-1:0]  o_g [3],
    output logic [2:0]            o_neg,
    output logic [SW-1:0]         o_s,
    output logic                  o_deg
);

    localparam int H  = (CM + 1) / 2;
    localparam int HI = CM - H;

    logic [2:0]           r_neg4, r_neg5, r_neg6;
    logic [2*HI-1:0]      r_hh [3];
    logic [HI+H-1:0]      r_hl [3];
    logic [2*H-1:0]       r_ll [3];
    logic [SQW-1:0]       r_sq [3];
    logic signed [RW-1:0] r_r  [3];
    logic signed [RW-1:0] r_g  [3];
    logic [SW-1:0]        r_s;
    logic                 r_deg;
    logic [CM-1:0]        w_mag [3];
    logic [SW-1:0]        w_sum;
    logic signed [RW-1:0] w_s;

    // magnitudes of the components
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_mag[a] = i_c[a][CPW-1] ? CM'(-i_c[a]) : CM'(i_c[a]);
        end
    end

    // split squares into half-width products
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int a = 0; a < 3; a++) begin
                r_neg4[a] <= i_c[a][CPW-1];
                r_hh[a]   <= w_mag[a][CM-1:H] * w_mag[a][CM-1:H];
                r_hl[a]   <= w_mag[a][CM-1:H] * w_mag[a][H-1:0];
                r_ll[a]   <= w_mag[a][H-1:0] * w_mag[a][H-1:0];
            end
        end
    end

    // recombine the partial products
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_neg5 <= r_neg4;
            for (int a = 0; a < 3; a++) begin
                r_sq[a] <= (SQW'(r_hh[a]) << (2 * H)) + (SQW'(r_hl[a]) << (H + 1))
                         + SQW'(r_ll[a]);
            end
        end
    end

    assign w_sum = SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
    assign w_s   = $signed(RW'(w_sum));

    // squared length, residual seed t - s and step seed -s
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_neg6 <= r_neg5;
            r_s    <= w_sum;
            r_deg  <= (w_sum == '0);
            for (int a = 0; a < 3; a++) begin
                r_r[a] <= ($signed(RW'(r_sq[a])) <<< (2 * NW - 2)) - w_s;
                r_g[a] <= -w_s;
            end
        end
    end

    assign o_r   = r_r;
    assign o_g   = r_g;
    assign o_neg = r_neg6;
    assign o_s   = r_s;
    assign o_deg = r_deg;

endmodule

// ----- rtl/tun_step.sv -----
// one bit of the exact rounding search for one normal component
module tun_step #(
    parameter int RW = 128,
    parameter int SW = 86,
    parameter int KW = 15,
    parameter int B  = 0
) (
    input  logic                 i_clk,
    input  tun_pkg::t_stage_ctl  i_ctl,
    input  logic signed [RW-1:0] i_r,
    input  logic signed [RW-1:0] i_g,
    input  logic [SW-1:0]        i_s,
    input  logic [KW-1:0]        i_k,
    output logic signed [RW-1:0] o_r,
    output logic signed [RW-1:0] o_g,
    output logic [KW-1:0]        o_k
);

    logic signed [RW-1:0] w_s;
    logic signed [RW-1:0] w_cand;
    logic                 w_fit;
    logic signed [RW-1:0] n_r, n_g;
    logic [KW-1:0]        n_k;
    logic signed [RW-1:0] r_r, r_g;
    logic [KW-1:0]        r_k;

    // residual if this bit of k is set: r - 4d*g - 4d*d*s
    assign w_s    = $signed(RW'(i_s));
    assign w_cand = i_r - (i_g <<< (B + 2)) - (w_s <<< (2 * B + 2));
    assign w_fit  = ~w_cand[RW-1];

    always_comb begin
        n_r    = w_fit ? w_cand : i_r;
        n_g    = w_fit ? (i_g + (w_s <<< (B + 1))) : i_g;
        n_k    = i_k;
        n_k[B] = w_fit;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_r <= n_r;
            r_g <= n_g;
            r_k <= n_k;
        end
    end

    assign o_r = r_r;
    assign o_g = r_g;
    assign o_k = r_k;

endmodule

// ----- rtl/triangle_unit_normal.sv -----
// top level: unit face normal of a triangle, fully pipelined
// throughput: one triangle per cycle while the output is not stalled, set by the per-bit rounding search stages
// a stalled output freezes the whole pipeline, nothing is dropped or repeated
// reset clears only the stage valid bits, data registers are not reset
module triangle_unit_normal #(
    parameter int COORD_WIDTH  = 20,
    parameter int NORMAL_WIDTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, zero pad
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // normal_x, normal_y, normal_z, zero pad
    output logic [((3*NORMAL_WIDTH+7)/8)*8-1:0] o_m_axis_tdata,
    // degenerate
    output logic o_m_axis_tuser
);

    localparam int CW  = COORD_WIDTH;
    localparam int NW  = NORMAL_WIDTH;
    localparam int ODW = ((3 * NW + 7) / 8) * 8;
    localparam int EW  = CW + 1;
    localparam int CPW = 2 * EW + 1;
    localparam int CM  = 2 * EW;
    localparam int SQW = 2 * CM;
    localparam int SW  = SQW + 2;
    localparam int RW  = SW + 2 * NW + tun_pkg::RES_GUARD;
    localparam int KW  = NW - 1;
    localparam int LAT = tun_pkg::CROSS_LAT + tun_pkg::SQUARE_LAT + KW + 1;
    localparam logic signed [NW-1:0] ONE = NW'(1) << (NW - 2);

    tun_pkg::t_stage_ctl  w_ctl;
    logic                 w_en;
    logic [LAT-1:0]       r_vld;
    logic signed [CPW-1:0] w_c [3];
    logic signed [RW-1:0] w_r [KW+1][3];
    logic signed [RW-1:0] w_g [KW+1][3];
    logic [KW-1:0]        w_k [KW+1][3];
    logic [2:0]           w_neg [KW+1];
    logic [SW-1:0]        w_len [KW+1];
    logic                 w_dgn [KW+1];
    logic [NW-1:0]        r_n [3];
    logic                 r_odeg;

    // pipeline advances unless the result register is held
    assign w_en            = ~r_vld[LAT-1] | i_m_axis_tready;
    assign w_ctl.en        = w_en;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_vld[LAT-1];

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_axis_tvalid};
        end
    end

    tun_cross #(.CW(CW), .EW(EW), .CPW(CPW)) u_cross (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_pts (i_s_axis_tdata[9*CW-1:0]),
        .o_c   (w_c)
    );

    tun_square #(.CPW(CPW), .CM(CM), .SQW(SQW), .SW(SW), .NW(NW), .RW(RW)) u_square (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_c   (w_c),
        .o_r   (w_r[0]),
        .o_g   (w_g[0]),
        .o_neg (w_neg[0]),
        .o_s   (w_len[0]),
        .o_deg (w_dgn[0])
    );

    assign w_k[0][0] = '0;
    assign w_k[0][1] = '0;
    assign w_k[0][2] = '0;

    // rounding search, most significant bit first
    for (genvar j = 0; j < KW; j++) begin : g_stage
        logic [2:0]    r_neg;
        logic [SW-1:0] r_s;
        logic          r_deg;

        for (genvar a = 0; a < 3; a++) begin : g_lane
            tun_step #(.RW(RW), .SW(SW), .KW(KW), .B(KW - 1 - j)) u_step (
                .i_clk (i_clk),
                .i_ctl (w_ctl),
                .i_r   (w_r[j][a]),
                .i_g   (w_g[j][a]),
                .i_s   (w_len[j]),
                .i_k   (w_k[j][a]),
                .o_r   (w_r[j+1][a]),
                .o_g   (w_g[j+1][a]),
                .o_k   (w_k[j+1][a])
            );
        end

        // side data travelling with the search
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_neg <= w_neg[j];
                r_s   <= w_len[j];
                r_deg <= w_dgn[j];
            end
        end

        assign w_neg[j+1] = r_neg;
        assign w_len[j+1] = r_s;
        assign w_dgn[j+1] = r_deg;
    end

    // sign, default normal for a zero cross product, result register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_odeg <= w_dgn[KW];
            for (int a = 0; a < 3; a++) begin
                if (w_dgn[KW]) begin
                    r_n[a] <= (a == 2) ? ONE : '0;
                end else if (w_neg[KW][a]) begin
                    r_n[a] <= -NW'(w_k[KW][a]);
                end else begin
                    r_n[a] <= NW'(w_k[KW][a]);
                end
            end
        end
    end

    assign o_m_axis_tdata = ODW'({r_n[2], r_n[1], r_n[0]});
    assign o_m_axis_tuser = r_odeg;

    // degenerate result carries the default normal
    a_deg_default: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |->
        (r_n[0] == '0 && r_n[1] == '0 && r_n[2] == ONE))
        else $error("degenerate result without default normal");

    // components never exceed one in magnitude
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
        ($signed(r_n[0]) <= ONE && $signed(r_n[0]) >= -ONE &&
         $signed(r_n[1]) <= ONE && $signed(r_n[1]) >= -ONE &&
         $signed(r_n[2]) <= ONE && $signed(r_n[2]) >= -ONE))
        else $error("normal component out of range");

    // a stall freezes every stage valid bit
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved during stall");

endmodule
